>>> src/b64lw_pkg.sv
package b64lw_pkg;

	localparam int unsigned MaxRun = 5;

	localparam logic [7:0] PadChar  = 8'h3d;
	localparam logic [7:0] NlChar   = 8'h0a;
	localparam logic [7:0] WrapRst  = 8'd72;
	localparam logic [7:0] ColMax   = 8'd252;
	localparam logic [5:0] SymMask  = 6'h3f;

	localparam logic KindData = 1'b0;
	localparam logic KindEnd  = 1'b1;

	// register index, taken from paddr[2]
	localparam logic RegWrap = 1'b0;

	// one run of result beats caused by a single input beat
	typedef struct packed {
		logic [MaxRun-1:0][7:0] chars;
		logic [2:0]             n;
		logic                   msg_end;
		logic                   marker;
	} run_t;

	// standard base64 alphabet
	function automatic logic [7:0] b64_sym(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26)
			return 8'h41 + w;
		else if (v < 6'd52)
			return 8'h61 + w - 8'd26;
		else if (v < 6'd62)
			return 8'h30 + w - 8'd52;
		else if (v == 6'd62)
			return 8'h2b;
		else
			return 8'h2f;
	endfunction

endpackage

>>> src/base64_line_wrapped_encoder_core.sv
// channel   dir   tdata            tuser                         tlast
// s_*       in    [7:0] data_byte  [0] kind (1 = end of message)  -
// m_*       out   [7:0] out_char   [0] char_valid [1] message_end last_of_run
// apb       in    [7:0] wrap_column at address 0, read back on prdata
//
// an input beat's run of 0 to 5 result beats is built combinationally and
// taken into a run register when the beat is accepted; from there the run moves
// into a drain shift register, which sends one result beat per cycle while the
// output is ready, so the output port sets the pace: three bytes give four or
// five beats.
// async active-low reset clears pending bytes, column count, valid bits and
// sets wrap_column to 72. input is taken while the drain is busy as long as
// the run register is free or hands its run to the drain at the same edge.
module base64_line_wrapped_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] kind
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_char
	output logic [1:0]  m_tuser,   // [0] char_valid, [1] message_end
	output logic        m_tlast,   // last_of_run
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration and encoder state
	logic [7:0]  wrap_q;
	logic [15:0] pend_q;
	logic [1:0]  pcnt_q;
	logic [7:0]  col_q;

	// run register between the encoder and the drain
	logic                run_vld_s1;
	b64lw_pkg::run_t     run_s1;

	// drain shift register; element 0 drives the output
	logic                          d_vld_q;
	logic [b64lw_pkg::MaxRun-1:0][7:0] d_chars_q;
	logic [2:0]                    d_left_q;
	logic                          d_end_q;
	logic                          d_marker_q;

	logic        in_acc, out_acc, d_load, d_last;
	logic [1:0]  cnt;
	logic [23:0] grp;
	logic [8:0]  col_sum;
	logic [7:0]  col_adv;
	logic        wrap_ok, do_nl;
	b64lw_pkg::run_t run_d;
	logic [15:0] pend_d;
	logic [1:0]  pcnt_d;
	logic [7:0]  col_d;
	logic        run_new;

	// apb: always ready, single register at address 0
	assign pready = 1'b1;
	assign prdata = (paddr[2] == b64lw_pkg::RegWrap) ? {24'd0, wrap_q} : 32'd0;

	// handshakes
	assign d_last   = (d_left_q == 3'd1);
	assign out_acc  = m_tvalid & m_tready;
	assign d_load   = run_vld_s1 & (~d_vld_q | (out_acc & d_last));
	assign s_tready = ~run_vld_s1 | d_load;
	assign in_acc   = s_tvalid & s_tready;

	// encoder: builds the run and next state for the beat on the input
	always_comb begin
		cnt     = (pcnt_q > 2'd2) ? 2'd2 : pcnt_q;
		col_sum = {1'b0, col_q} + 9'd4;
		col_adv = (col_sum > {1'b0, b64lw_pkg::ColMax}) ? b64lw_pkg::ColMax : col_sum[7:0];
		wrap_ok = (wrap_q != 8'd0) && (wrap_q[1:0] == 2'b00);
		do_nl   = wrap_ok && (col_adv >= wrap_q);

		run_d   = '0;
		run_new = 1'b0;
		pend_d  = 16'd0;
		pcnt_d  = 2'd0;
		col_d   = 8'd0;
		grp     = {pend_q, s_tdata};

		if (s_tuser[0] == b64lw_pkg::KindData) begin
			if (cnt < 2'd2) begin
				// just collect the byte
				pend_d = {pend_q[7:0], s_tdata};
				pcnt_d = cnt + 2'd1;
				col_d  = col_q;
			end else begin
				run_new         = 1'b1;
				run_d.chars[0]  = b64lw_pkg::b64_sym(grp[23:18]);
				run_d.chars[1]  = b64lw_pkg::b64_sym(grp[17:12]);
				run_d.chars[2]  = b64lw_pkg::b64_sym(grp[11:6]);
				run_d.chars[3]  = b64lw_pkg::b64_sym(grp[5:0] & b64lw_pkg::SymMask);
				run_d.chars[4]  = b64lw_pkg::NlChar;
				run_d.n         = do_nl ? 3'd5 : 3'd4;
				col_d           = do_nl ? 8'd0 : col_adv;
			end
		end else begin
			run_new = 1'b1;
			if (cnt == 2'd0) begin
				// nothing pending: a lone end marker
				run_d.n      = 3'd1;
				run_d.marker = 1'b1;
			end else begin
				grp = (cnt == 2'd1) ? {pend_q[7:0], 16'd0} : {pend_q, 8'd0};
				run_d.chars[0] = b64lw_pkg::b64_sym(grp[23:18]);
				run_d.chars[1] = b64lw_pkg::b64_sym(grp[17:12]);
				run_d.chars[2] = (cnt == 2'd1) ? b64lw_pkg::PadChar
				                               : b64lw_pkg::b64_sym(grp[11:6]);
				run_d.chars[3] = b64lw_pkg::PadChar;
				run_d.chars[4] = b64lw_pkg::NlChar;
				// newline only if the line has something on it
				run_d.n        = (col_q != 8'd0) ? 3'd5 : 3'd4;
			end
			run_d.msg_end = 1'b1;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q     <= b64lw_pkg::WrapRst;
			pend_q     <= 16'd0;
			pcnt_q     <= 2'd0;
			col_q      <= 8'd0;
			run_vld_s1 <= 1'b0;
			d_vld_q    <= 1'b0;
			d_left_q   <= 3'd0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == b64lw_pkg::RegWrap) begin
				wrap_q <= pwdata[7:0];
			end
			if (in_acc) begin
				pend_q <= pend_d;
				pcnt_q <= pcnt_d;
				col_q  <= col_d;
			end
			// run register fills on a producing beat, empties into the drain
			if (in_acc) begin
				run_vld_s1 <= run_new;
			end else if (d_load) begin
				run_vld_s1 <= 1'b0;
			end
			if (d_load) begin
				d_vld_q  <= 1'b1;
				d_left_q <= run_s1.n;
			end else if (out_acc) begin
				if (d_last) begin
					d_vld_q <= 1'b0;
				end
				d_left_q <= d_left_q - 3'd1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc && run_new) begin
			run_s1 <= run_d;
		end
		if (d_load) begin
			d_chars_q  <= run_s1.chars;
			d_end_q    <= run_s1.msg_end;
			d_marker_q <= run_s1.marker;
		end else if (out_acc) begin
			for (int i = 0; i < b64lw_pkg::MaxRun - 1; i++) begin
				d_chars_q[i] <= d_chars_q[i+1];
			end
		end
	end

	assign m_tvalid   = d_vld_q;
	assign m_tdata    = d_chars_q[0];
	assign m_tlast    = d_last;
	assign m_tuser[0] = ~d_marker_q;
	assign m_tuser[1] = d_end_q & d_last;

endmodule

>>> src/b64lw_checker.sv
module b64lw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [1:0] m_tuser,
	input logic       m_tlast
);

	// stalled output beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("output beat changed while stalled");

	// message end only on the last beat of a run
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("message_end without last_of_run");

	// empty marker is a lone, final, zero beat
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && m_tuser[1] && m_tdata == 8'd0)
		else $error("malformed end marker");

	// a newline always closes its run
	a_nl_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] && m_tdata == b64lw_pkg::NlChar |-> m_tlast)
		else $error("newline not at end of run");

endmodule

bind base64_line_wrapped_encoder_core b64lw_checker u_b64lw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

>>> bench/b64lw_stream_checker.sv
`timescale 1ns / 100ps

module b64lw_stream_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] kind
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [7:0] out_char
	input  logic [1:0]  m_tuser,   // [0] char_valid, [1] message_end
	input  logic        m_tlast,   // last_of_run
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          awaited
);

	typedef struct packed {
		logic [7:0] ch;
		logic       char_valid;
		logic       run_last;
		logic       msg_end;
	} enc_beat_t;

	enc_beat_t   char_q[$];
	logic [15:0] held_bytes;
	logic [1:0]  held_cnt;
	logic [7:0]  line_col;
	logic [7:0]  wrap_col;
	int          err_total;

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] idx;
		idx = {2'b00, v};
		if (idx < 8'd26)
			return 8'h41 + idx;
		if (idx < 8'd52)
			return 8'h61 + (idx - 8'd26);
		if (idx < 8'd62)
			return 8'h30 + (idx - 8'd52);
		return (idx == 8'd62) ? 8'h2b : 8'h2f;
	endfunction

	task automatic push_char(input logic [7:0] ch, input logic cv, input logic last,
			input logic mend);
		enc_beat_t b;
		b.ch = ch;
		b.char_valid = cv;
		b.run_last = last;
		b.msg_end = mend;
		char_q.push_back(b);
	endtask

	task automatic encode_beat(input logic kind, input logic [7:0] b);
		logic [23:0] grp;
		logic [1:0]  cnt;
		logic [7:0]  next_col;
		logic        wrap_now;
		logic        nl;
		cnt = (held_cnt == 2'd3) ? 2'd2 : held_cnt;
		if (kind == b64lw_pkg::KindData) begin
			if (cnt != 2'd2) begin
				held_bytes = {held_bytes[7:0], b};
				held_cnt = cnt + 2'd1;
			end else begin
				grp = {held_bytes, b};
				// column count sticks at its ceiling rather than rolling over
				next_col = (line_col > b64lw_pkg::ColMax - 8'd4) ? b64lw_pkg::ColMax
				                                                 : line_col + 8'd4;
				wrap_now = wrap_col != 8'd0 && wrap_col[1:0] == 2'b00 && next_col >= wrap_col;
				push_char(sextet_char(grp[23:18]), 1'b1, 1'b0, 1'b0);
				push_char(sextet_char(grp[17:12]), 1'b1, 1'b0, 1'b0);
				push_char(sextet_char(grp[11:6]), 1'b1, 1'b0, 1'b0);
				push_char(sextet_char(grp[5:0]), 1'b1, !wrap_now, 1'b0);
				if (wrap_now)
					push_char(b64lw_pkg::NlChar, 1'b1, 1'b1, 1'b0);
				line_col = wrap_now ? 8'd0 : next_col;
				held_bytes = '0;
				held_cnt = '0;
			end
		end else begin
			if (cnt == 2'd0) begin
				push_char(8'h00, 1'b0, 1'b1, 1'b1);
			end else begin
				grp = (cnt == 2'd1) ? {held_bytes[7:0], 16'h0000} : {held_bytes, 8'h00};
				nl = line_col != 8'd0;
				push_char(sextet_char(grp[23:18]), 1'b1, 1'b0, 1'b0);
				push_char(sextet_char(grp[17:12]), 1'b1, 1'b0, 1'b0);
				push_char((cnt == 2'd1) ? b64lw_pkg::PadChar : sextet_char(grp[11:6]),
					1'b1, 1'b0, 1'b0);
				push_char(b64lw_pkg::PadChar, 1'b1, !nl, !nl);
				if (nl)
					push_char(b64lw_pkg::NlChar, 1'b1, 1'b1, 1'b1);
			end
			held_bytes = '0;
			held_cnt = '0;
			line_col = '0;
		end
	endtask

	task automatic check_beat();
		enc_beat_t want;
		if (char_q.size() == 0) begin
			$error("output beat with nothing awaited: out_char %h", m_tdata);
			err_total++;
		end else begin
			want = char_q.pop_front();
			if (m_tdata !== want.ch) begin
				$error("out_char: expected %h, got %h", want.ch, m_tdata);
				err_total++;
			end
			if (m_tuser[0] !== want.char_valid) begin
				$error("char_valid: expected %b, got %b", want.char_valid, m_tuser[0]);
				err_total++;
			end
			if (m_tlast !== want.run_last) begin
				$error("last_of_run: expected %b, got %b", want.run_last, m_tlast);
				err_total++;
			end
			if (m_tuser[1] !== want.msg_end) begin
				$error("message_end: expected %b, got %b", want.msg_end, m_tuser[1]);
				err_total++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_q.delete();
			held_bytes = '0;
			held_cnt = '0;
			line_col = '0;
			wrap_col = b64lw_pkg::WrapRst;
			err_total = 0;
			mismatches <= 0;
			awaited <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_beat();
			if (s_tvalid && s_tready)
				encode_beat(s_tuser[0], s_tdata);
			if (psel && penable && pwrite && pready && paddr[2] == b64lw_pkg::RegWrap)
				wrap_col = pwdata[7:0];
			mismatches <= err_total;
			awaited <= char_q.size();
		end
	end

endmodule

>>> bench/base64_line_wrapped_encoder_core_tb.sv
`timescale 1ns / 100ps

module base64_line_wrapped_encoder_core_tb;

	// byte addresses of the wrap register and of an index that decodes to nothing
	localparam logic [2:0] WrapAddr   = {b64lw_pkg::RegWrap, 2'b00};
	localparam logic [2:0] UnusedAddr = {~b64lw_pkg::RegWrap, 2'b00};
	// quiet cycles before the run is declared hung
	localparam int StallLimit   = 2000;
	// cycles let pass after the last awaited beat before touching the register
	localparam int SettleCycles = 6;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;   // [7:0] data_byte
	logic [0:0]  s_tuser  = '0;   // [0] kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // [7:0] out_char
	logic [1:0]  m_tuser;         // [0] char_valid, [1] message_end
	logic        m_tlast;         // last_of_run
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	int fail_total;
	int awaited;
	int quiet_cycles = 0;
	int send_idle_pct = 6;
	int recv_idle_pct = 69;

	base64_line_wrapped_encoder_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// watches both streams and the register port, predicts and compares
	b64lw_stream_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.mismatches (fail_total),
		.awaited    (awaited)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// hang detection: any accepted beat on either stream clears the count
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= StallLimit) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [7:0] rand_byte();
		// lean on the all-zero and all-one bytes now and then
		case ($urandom_range(5))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// offer one beat, idling first at the sender's rate; valid stays up after
	// the handshake so back-to-back beats need no second assignment in a step
	task automatic put_beat(input logic kind, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= kind;
		do @(posedge clk); while (!s_tready);
	endtask

	// bytes go out from the most significant end of the vector
	task automatic put_bytes(input logic [95:0] bytes, input int count);
		int i;
		for (i = count - 1; i >= 0; i--)
			put_beat(b64lw_pkg::KindData, bytes[i*8 +: 8]);
	endtask

	task automatic put_data(input int len);
		repeat (len) put_beat(b64lw_pkg::KindData, rand_byte());
	endtask

	task automatic put_end();
		// data byte is a don't-care on an end beat, so randomize it
		put_beat(b64lw_pkg::KindEnd, rand_byte());
	endtask

	// mostly short messages, an occasional longer one that crosses lines
	task automatic rand_messages(input int budget);
		int sent;
		int len;
		sent = 0;
		while (sent < budget) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(9);
			put_data(len);
			put_end();
			sent += len + 1;
		end
	endtask

	// hold the sender until every awaited beat is out, then let the block settle
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// setup cycle then access cycle; upper data bits carry junk
	task automatic write_reg(input logic [2:0] addr, input logic [7:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= ($urandom & 32'hffff_ff00) | {24'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- sender idles lightly, receiver heavily ---
		send_idle_pct = 6;
		recv_idle_pct = 69;

		// directed beats with the reset wrap of 72
		put_end();                                     // empty message, lone marker
		put_bytes(96'h00, 1);                          // one byte, double pad
		put_end();
		put_bytes(96'hffff, 2);                        // two bytes, single pad
		put_end();
		put_bytes(96'hfbefbe_ffffff_000000, 9);        // '+', '/' and 'A' runs
		put_end();                                     // nothing pending, mid-line marker
		put_bytes(96'h4d616e_80, 4);                   // full group then a pad
		put_end();                                     // nonzero column gives newline

		// write to an unused index must leave the wrap setting alone
		wait_drain();
		write_reg(UnusedAddr, 8'd4);
		put_bytes(96'h102030_405060_708090, 9);
		put_end();

		// every group wraps, so the final padded group finds column zero
		wait_drain();
		write_reg(WrapAddr, 8'd4);
		put_bytes(96'h010203_7f80, 5);
		put_end();
		rand_messages(3);

		// wrap lowered below the running column in the middle of a line
		wait_drain();
		write_reg(WrapAddr, 8'd72);
		rand_messages(3);
		put_data(12);
		wait_drain();
		write_reg(WrapAddr, 8'd8);
		put_data(5);
		put_end();
		rand_messages(3);

		// --- sender idles heavily, receiver lightly ---
		wait_drain();
		send_idle_pct = 69;
		recv_idle_pct = 6;

		// no wrap: column runs into its ceiling, then the top setting fires
		write_reg(WrapAddr, 8'd0);
		put_data(192);
		wait_drain();
		write_reg(WrapAddr, 8'd252);
		put_data(4);
		put_end();
		rand_messages(3);

		// a setting that is not a multiple of four never wraps
		wait_drain();
		write_reg(WrapAddr, 8'd7);
		rand_messages(3);

		wait_drain();
		write_reg(WrapAddr, {6'($urandom_range(63)), 2'b00});
		rand_messages(3);

		// --- neither side idles ---
		wait_drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;

		write_reg(WrapAddr, 8'd12);
		rand_messages(3);

		wait_drain();
		write_reg(WrapAddr, 8'($urandom_range(255)));
		rand_messages(3);

		wait_drain();
		write_reg(WrapAddr, 8'd72);
		rand_messages(3);

		wait_drain();
		if (fail_total == 0 && awaited == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
